FILE: src/vrmt_pkg.sv
// Shared types and constants for the virtual range mapping table.
package vrmt_pkg;

	localparam int ADDR_W      = 64;
	localparam int ATTR_W      = 64;
	localparam int PAGE_SHIFT  = 12;
	localparam int VA_BITS     = 48;
	localparam int VPAGE_W     = VA_BITS - PAGE_SHIFT;
	localparam int NPAGE_W     = VPAGE_W + 1;
	localparam int PPAGE_W     = ADDR_W - PAGE_SHIFT;
	localparam int SUM_W       = VPAGE_W + 2;
	localparam int STATUS_W    = 3;
	localparam int QUEUE_DEPTH = 2;

	localparam logic FUNC_MAP   = 1'b0;
	localparam logic FUNC_UNMAP = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_NO_INIT   = 3'd1,
		ST_BAD_VALUE = 3'd2,
		ST_BUSY      = 3'd3,
		ST_FULL      = 3'd4,
		ST_NOT_FOUND = 3'd5
	} resp_code_t;

	typedef enum logic [1:0] {
		JOB_DONE,
		JOB_MAP,
		JOB_UNMAP
	} job_kind_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_SCAN,
		BK_RESP
	} back_state_t;

	typedef struct packed {
		job_kind_t            kind;
		resp_code_t           status;
		logic [VPAGE_W-1:0]   vpage;
		logic [NPAGE_W-1:0]   npages;
		logic [PPAGE_W-1:0]   ppage;
		logic [ATTR_W-1:0]    attr;
	} job_t;

endpackage

FILE: src/vrmt_queue.sv
// Short job queue between the request checker and the table scanner.
module vrmt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  vrmt_pkg::job_t push_job,
	output logic           pop_valid,
	input  logic           pop_ready,
	output vrmt_pkg::job_t pop_job
);
	import vrmt_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Depth is a power of two, so the pointers wrap on their own.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!do_push && do_pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: src/vrmt_front.sv
// Request capture and argument checks; classifies each request into a job.
module vrmt_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         enabled,
	input  logic                         clearing,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic                         func,
	input  logic [vrmt_pkg::ADDR_W-1:0]  virt_addr,
	input  logic [vrmt_pkg::ADDR_W-1:0]  phys_addr,
	input  logic [vrmt_pkg::ADDR_W-1:0]  range_size,
	input  logic [vrmt_pkg::ATTR_W-1:0]  map_flags,
	output logic                         push_valid,
	input  logic                         push_ready,
	output vrmt_pkg::job_t               push_job
);
	import vrmt_pkg::*;

	logic                valid_s1;
	logic                en_s1;
	logic                func_s1;
	logic [ADDR_W-1:0]   va_s1;
	logic [ADDR_W-1:0]   pa_s1;
	logic [ADDR_W-1:0]   len_s1;
	logic [ATTR_W-1:0]   attr_s1;

	logic                accept;
	logic [ADDR_W:0]     vsum;
	logic [ADDR_W:0]     psum;
	logic                va_ok;
	logic                pa_ok;

	assign req_stall  = clearing || (valid_s1 && !push_ready);
	assign accept     = req_valid && !req_stall;
	assign push_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			en_s1   <= enabled;
			func_s1 <= func;
			va_s1   <= virt_addr;
			pa_s1   <= phys_addr;
			len_s1  <= range_size;
			attr_s1 <= map_flags;
		end
	end

	assign vsum = {1'b0, va_s1} + {1'b0, len_s1};
	assign psum = {1'b0, pa_s1} + {1'b0, len_s1};

	// Virtual end must land at or below the top of the 48-bit space.
	assign va_ok = (va_s1 != '0) && (len_s1 != '0) &&
		(va_s1[PAGE_SHIFT-1:0] == '0) && (len_s1[PAGE_SHIFT-1:0] == '0) &&
		(va_s1[ADDR_W-1:VA_BITS] == '0) &&
		(vsum[ADDR_W:VA_BITS+1] == '0) &&
		!(vsum[VA_BITS] && (vsum[VA_BITS-1:0] != '0));

	assign pa_ok = (pa_s1 != '0) && (pa_s1[PAGE_SHIFT-1:0] == '0) && !psum[ADDR_W];

	always_comb begin
		push_job.vpage  = va_s1[VA_BITS-1:PAGE_SHIFT];
		push_job.npages = len_s1[VA_BITS:PAGE_SHIFT];
		push_job.ppage  = pa_s1[ADDR_W-1:PAGE_SHIFT];
		push_job.attr   = attr_s1;
		push_job.status = ST_OK;
		push_job.kind   = (func_s1 == FUNC_UNMAP) ? JOB_UNMAP : JOB_MAP;
		if (!en_s1) begin
			push_job.kind   = JOB_DONE;
			push_job.status = ST_NO_INIT;
		end else if (!va_ok || ((func_s1 == FUNC_MAP) && !pa_ok)) begin
			push_job.kind   = JOB_DONE;
			push_job.status = ST_BAD_VALUE;
		end
	end

endmodule

FILE: src/vrmt_back.sv
// Table scanner: holds the mapping table, searches it, updates it, drives results.
module vrmt_back #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pop_valid,
	output logic                           pop_ready,
	input  vrmt_pkg::job_t                 pop_job,
	output logic                           clearing,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [vrmt_pkg::STATUS_W-1:0]  status
);
	import vrmt_pkg::*;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_ENTRIES - 1);

	// Table storage
	logic                valid_mem [TABLE_ENTRIES];
	logic [VPAGE_W-1:0]  vpage_mem [TABLE_ENTRIES];
	logic [NPAGE_W-1:0]  npage_mem [TABLE_ENTRIES];
	logic [PPAGE_W-1:0]  ppage_mem [TABLE_ENTRIES];
	logic [ATTR_W-1:0]   attr_mem  [TABLE_ENTRIES];

	back_state_t         state_q, state_d;
	logic [IDX_W-1:0]    clr_q;
	logic [IDX_W-1:0]    issue_q;
	logic                issuing_q;
	logic                rd_vld_s1;
	logic [IDX_W-1:0]    rd_idx_s1;
	logic                rd_valid_s1;
	logic [VPAGE_W-1:0]  rd_vpage_s1;
	logic [NPAGE_W-1:0]  rd_npages_s1;
	job_t                job_q;
	logic [SUM_W-1:0]    job_end_q;
	logic                free_found_q;
	logic [IDX_W-1:0]    slot_q;
	resp_code_t          res_q;
	logic                out_valid_q;
	resp_code_t          out_status_q;

	logic                job_load;
	logic                clr_adv;
	logic                issue_en;
	logic                finish;
	resp_code_t          fin_status;
	logic                out_load;
	logic                out_free;
	logic [SUM_W-1:0]    slot_end;
	logic                overlap;
	logic                match;
	logic                take_free;
	logic                take_hit;
	logic                tbl_write;
	logic                vwr_en;
	logic [IDX_W-1:0]    vwr_addr;
	logic                vwr_data;

	assign slot_end  = SUM_W'(rd_vpage_s1) + SUM_W'(rd_npages_s1);
	assign overlap   = rd_valid_s1 && (SUM_W'(job_q.vpage) < slot_end) &&
		(SUM_W'(rd_vpage_s1) < job_end_q);
	assign match     = rd_valid_s1 && (rd_vpage_s1 == job_q.vpage) &&
		(rd_npages_s1 == job_q.npages);
	assign out_free  = !out_valid_q || !rsp_stall;
	assign clearing  = (state_q == BK_CLEAR);
	assign take_free = (state_q == BK_SCAN) && rd_vld_s1 && (job_q.kind == JOB_MAP) &&
		!rd_valid_s1 && !free_found_q;
	assign take_hit  = (state_q == BK_SCAN) && rd_vld_s1 && (job_q.kind == JOB_UNMAP) && match;
	assign tbl_write = out_load && (res_q == ST_OK) && (job_q.kind != JOB_DONE);

	always_comb begin
		state_d    = state_q;
		pop_ready  = 1'b0;
		job_load   = 1'b0;
		clr_adv    = 1'b0;
		issue_en   = 1'b0;
		finish     = 1'b0;
		fin_status = ST_OK;
		out_load   = 1'b0;
		case (state_q)
			BK_CLEAR: begin
				clr_adv = 1'b1;
				if (clr_q == LAST) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					job_load = 1'b1;
					state_d  = (pop_job.kind == JOB_DONE) ? BK_RESP : BK_SCAN;
				end
			end
			BK_SCAN: begin
				issue_en = issuing_q;
				if (rd_vld_s1) begin
					if (job_q.kind == JOB_MAP) begin
						if (overlap) begin
							finish     = 1'b1;
							fin_status = ST_BUSY;
						end else if (rd_idx_s1 == LAST) begin
							finish     = 1'b1;
							fin_status = (free_found_q || !rd_valid_s1) ? ST_OK : ST_FULL;
						end
					end else begin
						if (match) begin
							finish     = 1'b1;
							fin_status = ST_OK;
						end else if (rd_idx_s1 == LAST) begin
							finish     = 1'b1;
							fin_status = ST_NOT_FOUND;
						end
					end
				end
				if (finish) begin
					state_d = BK_RESP;
				end
			end
			BK_RESP: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_CLEAR;
			clr_q        <= '0;
			issue_q      <= '0;
			issuing_q    <= 1'b0;
			rd_vld_s1    <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue_en;
			if (clr_adv) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (job_load) begin
				issue_q      <= '0;
				issuing_q    <= 1'b1;
				free_found_q <= 1'b0;
			end else begin
				if (issue_en) begin
					if (issue_q == LAST) begin
						issuing_q <= 1'b0;
					end else begin
						issue_q <= issue_q + IDX_W'(1);
					end
				end
				if (take_free) begin
					free_found_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= issue_q;
		if (job_load) begin
			job_q     <= pop_job;
			job_end_q <= SUM_W'(pop_job.vpage) + SUM_W'(pop_job.npages);
			res_q     <= pop_job.status;
		end
		if (finish) begin
			res_q <= fin_status;
		end
		if (take_free || take_hit) begin
			slot_q <= rd_idx_s1;
		end
		if (out_load) begin
			out_status_q <= res_q;
		end
	end

	// Valid bits: cleared by the pass after reset, set on map, dropped on unmap.
	assign vwr_en   = clr_adv || tbl_write;
	assign vwr_addr = clr_adv ? clr_q : slot_q;
	assign vwr_data = !clr_adv && (job_q.kind == JOB_MAP);

	always_ff @(posedge clk) begin
		if (vwr_en) begin
			valid_mem[vwr_addr] <= vwr_data;
		end
		rd_valid_s1 <= valid_mem[issue_q];
	end

	always_ff @(posedge clk) begin
		if (tbl_write && (job_q.kind == JOB_MAP)) begin
			vpage_mem[slot_q] <= job_q.vpage;
			npage_mem[slot_q] <= job_q.npages;
			ppage_mem[slot_q] <= job_q.ppage;
			attr_mem[slot_q]  <= job_q.attr;
		end
		rd_vpage_s1  <= vpage_mem[issue_q];
		rd_npages_s1 <= npage_mem[issue_q];
	end

	assign rsp_valid = out_valid_q;
	assign status    = out_status_q;

endmodule

FILE: src/va_range_mapping_table_unit.sv
// Virtual-to-physical range mapping table with map and unmap requests.
// A request failing the checks skips the table scan and goes straight to the response state;
// one that scans reads one table entry per cycle and can end early on an overlap or a match.
// The back end handles one request at a time; the queue lets the front take more meanwhile.
// Reset: control clears at once, then a pass over every entry clears the valid bits;
// req_stall stays high during that pass while the config port still takes writes.
module va_range_mapping_table_unit #(
	parameter int TABLE_ENTRIES = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic                           cfg_data,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic                           func,
	input  logic [vrmt_pkg::ADDR_W-1:0]    virt_addr,
	input  logic [vrmt_pkg::ADDR_W-1:0]    phys_addr,
	input  logic [vrmt_pkg::ADDR_W-1:0]    range_size,
	input  logic [vrmt_pkg::ATTR_W-1:0]    map_flags,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [vrmt_pkg::STATUS_W-1:0]  status
);
	import vrmt_pkg::*;

	logic  enabled_q;
	logic  clearing;
	logic  push_valid;
	logic  push_ready;
	job_t  push_job;
	logic  pop_valid;
	logic  pop_ready;
	job_t  pop_job;

	// The enable register always takes a write; the user must write it only while idle, the block does not enforce this.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			enabled_q <= cfg_data;
		end
	end

	// Front: capture each request and settle every check that needs no table access.
	vrmt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.enabled    (enabled_q),
		.clearing   (clearing),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.func       (func),
		.virt_addr  (virt_addr),
		.phys_addr  (phys_addr),
		.range_size (range_size),
		.map_flags  (map_flags),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	// Hold classified jobs so the front keeps taking requests during a scan until the queue fills.
	vrmt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	// Back: scan the table for overlap, a free slot or an exact match, then
	// update the table and drive the result through its output register.
	vrmt_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job),
		.clearing  (clearing),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status)
	);

endmodule
